// ===== design/assert_macros.svh =====
// Assertion macros shared by the dispatch block.
// No dependencies; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define LLSD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("check failed: lbl");

// When the antecedent holds, the consequent must hold at the same edge.
`define LLSD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: lbl");

// When the antecedent holds, the consequent must hold at the next edge.
`define LLSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: lbl");

`endif

// ===== design/llsd_pkg.sv =====
// Shared constants, types and helpers for the least-loaded dispatch block.
// No dependencies; used by llsd_cell and least_loaded_server_dispatch.
package llsd_pkg;

  localparam int SERVERS  = 8;
  localparam int IDX_W    = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int CNT_W    = $clog2(SERVERS + 1);
  localparam int LOAD_W   = 32;
  localparam int TIME_W   = 16;
  localparam int TILLS_W  = 4;
  localparam int OIDX_W   = 3;
  localparam int OUT_W    = OIDX_W + 2 * LOAD_W;
  localparam int TDATA_W  = ((OUT_W + 7) / 8) * 8;

  // Search token that travels down the chain of cells.
  typedef struct packed {
    logic              live;
    logic              found;
    logic [LOAD_W-1:0] load;
    logic [IDX_W-1:0]  idx;
  } tok_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic              clr;
    logic [IDX_W-1:0]  idx;
    logic [LOAD_W-1:0] load;
  } wr_t;

  // A count of zero acts as one, a count above the build size as the build size.
  function automatic logic [CNT_W-1:0] tills_in_use(input logic [TILLS_W-1:0] num);
    logic [31:0] v;
    v = {{(32 - TILLS_W){1'b0}}, num};
    if (v == 32'd0) v = 32'd1;
    if (v > 32'(SERVERS)) v = 32'(SERVERS);
    return v[CNT_W-1:0];
  endfunction

endpackage

// ===== design/llsd_cell.sv =====
// One server's load register and its stage of the minimum search chain.
// Depends on llsd_pkg.
module llsd_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [llsd_pkg::IDX_W-1:0]      cell_idx,
  input  logic [llsd_pkg::CNT_W-1:0]      tills,
  input  llsd_pkg::tok_t                  tok_in,
  output llsd_pkg::tok_t                  tok_out,
  input  llsd_pkg::wr_t                   wr
);

  logic [llsd_pkg::LOAD_W-1:0] load;
  logic                        in_use;
  logic                        take;

  assign in_use = 32'(cell_idx) < 32'(tills);
  // Strictly less keeps the earlier, lower-indexed server on a tie.
  assign take   = in_use && (!tok_in.found || (load < tok_in.load));

  always_ff @(posedge clk) begin
    if (rst) begin
      load <= '0;
    end else if (wr.clr) begin
      load <= '0;
    end else if (wr.en && (wr.idx == cell_idx)) begin
      load <= wr.load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.live <= 1'b0;
    end else begin
      tok_out.live <= tok_in.live;
    end
    if (take) begin
      tok_out.found <= 1'b1;
      tok_out.load  <= load;
      tok_out.idx   <= cell_idx;
    end else begin
      tok_out.found <= tok_in.found;
      tok_out.load  <= tok_in.load;
      tok_out.idx   <= tok_in.idx;
    end
  end

endmodule

// ===== design/least_loaded_server_dispatch.sv =====
// One job in flight: the input is ready only in the idle state, so a new job is
// taken once the previous one has been written, and the search token walks the
// chain one cell per cycle.
// A finished result waits in the output register while the next job is taken.
// Synchronous active-high reset clears all loads, the makespan and sets the
// server count to one.
// Depends on llsd_pkg, llsd_cell and assert_macros.svh.
`include "assert_macros.svh"

module least_loaded_server_dispatch (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [llsd_pkg::TILLS_W-1:0]      cfg_data,     // num_tills
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [llsd_pkg::TIME_W-1:0]       s_tdata,      // service_time
  input  logic                              s_tlast,      // last_job
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // server_index [2:0], server_load [34:3], makespan [66:35], zero fill above
  output logic [llsd_pkg::TDATA_W-1:0]      m_tdata,
  output logic                              m_tlast       // batch_done
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0]                         state;
  logic [llsd_pkg::TILLS_W-1:0]       num_tills;
  logic [llsd_pkg::CNT_W-1:0]         tills;
  logic [llsd_pkg::TIME_W-1:0]        svc;
  logic                               last;
  logic [llsd_pkg::LOAD_W-1:0]        sum;
  logic [llsd_pkg::IDX_W-1:0]         best_idx;
  logic [llsd_pkg::LOAD_W-1:0]        makespan;
  logic [llsd_pkg::LOAD_W-1:0]        ms_next;
  logic [llsd_pkg::LOAD_W:0]          sum_wide;
  logic [31:0]                        idx_ext;
  logic                               in_fire;
  logic                               out_free;
  logic                               commit;
  llsd_pkg::tok_t                     tok [llsd_pkg::SERVERS+1];
  llsd_pkg::wr_t                      wr;
  logic [llsd_pkg::SERVERS-1:0]       live_bits;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign commit    = (state == S_WRITE) && out_free;
  assign tills     = llsd_pkg::tills_in_use(num_tills);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_tills <= llsd_pkg::TILLS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      num_tills <= cfg_data;
    end
  end

  // The token enters the head cell on the beat that accepts the job.
  assign tok[0] = '{live: in_fire, found: 1'b0, load: '0, idx: '0};

  for (genvar i = 0; i < llsd_pkg::SERVERS; i++) begin : g_cell
    llsd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (llsd_pkg::IDX_W'(i)),
      .tills    (tills),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .wr       (wr)
    );
    assign live_bits[i] = tok[i+1].live;
  end

  assign sum_wide = {1'b0, tok[llsd_pkg::SERVERS].load}
                  + {{(llsd_pkg::LOAD_W + 1 - llsd_pkg::TIME_W){1'b0}}, svc};
  assign ms_next  = (sum > makespan) ? sum : makespan;
  assign idx_ext  = 32'(best_idx);

  always_comb begin
    wr.en   = commit;
    wr.clr  = commit && last;
    wr.idx  = best_idx;
    wr.load = sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      makespan <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) state <= S_SCAN;
        end
        S_SCAN: begin
          if (tok[llsd_pkg::SERVERS].live) state <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            state    <= S_IDLE;
            makespan <= last ? '0 : ms_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      svc  <= s_tdata;
      last <= s_tlast;
    end
    if ((state == S_SCAN) && tok[llsd_pkg::SERVERS].live) begin
      // Loads saturate at the all-ones value.
      sum      <= sum_wide[llsd_pkg::LOAD_W] ? '1 : sum_wide[llsd_pkg::LOAD_W-1:0];
      best_idx <= tok[llsd_pkg::SERVERS].idx;
    end
    if (commit) begin
      m_tdata <= {{(llsd_pkg::TDATA_W - llsd_pkg::OUT_W){1'b0}}, ms_next, sum,
                  idx_ext[llsd_pkg::OIDX_W-1:0]};
      m_tlast <= last;
    end
  end

  `LLSD_ASSERT_ALWAYS(a_one_token, $onehot0(live_bits))
  `LLSD_ASSERT_SAME(a_tail_in_scan, tok[llsd_pkg::SERVERS].live, state == S_SCAN)
  `LLSD_ASSERT_NEXT(a_commit_shows, commit, m_tvalid && (state == S_IDLE))
  `LLSD_ASSERT_SAME(a_ms_covers_load, m_tvalid, m_tdata[66:35] >= m_tdata[34:3])

endmodule

// ===== verif/tb_least_loaded_server_dispatch.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for least_loaded_server_dispatch.
// It predicts server choice, load and makespan per job and checks every result beat.
// Depends on llsd_pkg and the dispatch RTL only.

module tb_least_loaded_server_dispatch;

  localparam int LIMIT_CYCLES    = 3_000_000;
  localparam int PRESSURE_CYCLES = 200;
  localparam int RANDOM_PHASES   = 11;
  localparam int JOBS_PER_PHASE  = 45;
  localparam int FILL_JOBS       = 16;
  localparam int IDX_LSB         = 0;
  localparam int LOAD_LSB        = 3;
  localparam int SPAN_LSB        = 35;

  typedef struct packed {
    logic [2:0]  server_index;
    logic [31:0] server_load;
    logic [31:0] makespan;
    logic        batch_done;
  } dispatch_t;

  logic                                 clk       = 1'b0;
  logic                                 rst       = 1'b1;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [llsd_pkg::TILLS_W-1:0]         cfg_data  = '0;
  logic                                 s_tvalid  = 1'b0;
  logic                                 s_tready;
  logic [llsd_pkg::TIME_W-1:0]          s_tdata   = '0;
  logic                                 s_tlast   = 1'b0;
  logic                                 m_tvalid;
  logic                                 m_tready  = 1'b0;
  logic [llsd_pkg::TDATA_W-1:0]         m_tdata;
  logic                                 m_tlast;

  // Predicted state of the dispatcher.
  logic [31:0]                  predicted_loads [llsd_pkg::SERVERS];
  logic [31:0]                  predicted_makespan;
  logic [llsd_pkg::TILLS_W-1:0] tills_setting;
  dispatch_t                    pending_dispatches [$];

  int   error_count        = 0;
  int   jobs_accepted      = 0;
  int   batches_closed     = 0;
  int   saturated_jobs     = 0;
  int   tills_writes       = 0;
  int   input_stall_cycles = 0;
  int   cycle_count        = 0;
  int   hold_off_left      = 0;
  int   burst_left         = 0;
  int   pattern_age        = 0;
  bit   steady             = 1'b0;
  logic [15:0] ready_pattern = '1;

  least_loaded_server_dispatch u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Greedy choice over the servers in use; loads of servers that dropped out stay.
  function automatic dispatch_t assign_job(input logic [15:0] service, input logic last);
    int          n;
    int          best;
    logic [32:0] sum;
    dispatch_t   d;
    n = int'(tills_setting);
    if (n == 0) n = 1;
    if (n > llsd_pkg::SERVERS) n = llsd_pkg::SERVERS;
    best = 0;
    for (int i = 1; i < n; i++) begin
      if (predicted_loads[i] < predicted_loads[best]) best = i;
    end
    sum = {1'b0, predicted_loads[best]} + 33'(service);
    if (sum[32]) begin
      d.server_load = '1;
      saturated_jobs++;
    end else begin
      d.server_load = sum[31:0];
    end
    predicted_loads[best] = d.server_load;
    if (d.server_load > predicted_makespan) predicted_makespan = d.server_load;
    d.server_index = best[2:0];
    d.makespan     = predicted_makespan;
    d.batch_done   = last;
    if (last) begin
      for (int i = 0; i < llsd_pkg::SERVERS; i++) predicted_loads[i] = '0;
      predicted_makespan = '0;
      batches_closed++;
    end
    return d;
  endfunction

  function automatic logic [15:0] random_service_time();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one job, with bursts and gaps unless the run is steady.
  task automatic send_job(input logic [15:0] service, input logic last);
    @(negedge clk);
    if (!steady) begin
      if (burst_left == 0) begin
        s_tvalid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      end
      burst_left--;
    end
    s_tvalid = 1'b1;
    s_tdata  = service;
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    pending_dispatches.push_back(assign_job(service, last));
    jobs_accepted++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_dispatches.size() != 0) @(posedge clk);
  endtask

  task automatic write_tills(input logic [llsd_pkg::TILLS_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    tills_setting = value;
    tills_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic check_single_server_after_reset();
    send_job(16'h0000, 1'b0);
    send_job(16'hFFFF, 1'b0);
    send_job(16'h0001, 1'b1);
  endtask

  // A count of zero acts as one, fifteen as the full build; ties go low; the count
  // then shrinks in the middle of a batch and grows again for a new batch.
  task automatic check_tills_clamping_and_ties();
    write_tills(4'd0);
    send_job(16'd5, 1'b0);
    send_job(16'd7, 1'b1);
    write_tills(4'd15);
    repeat (9) send_job(16'h1234, 1'b0);
    send_job(16'h0000, 1'b0);
    write_tills(4'd3);
    send_job(16'hAAAA, 1'b0);
    send_job(16'h5555, 1'b1);
    write_tills(4'd8);
    send_job(16'h8000, 1'b0);
    send_job(16'h7FFF, 1'b0);
    send_job(16'hFFFF, 1'b1);
  endtask

  // One server takes a back-to-back run of the longest jobs with the receiver always ready.
  task automatic check_steady_single_server();
    write_tills(4'd1);
    @(posedge clk);
    steady = 1'b1;
    repeat (FILL_JOBS) send_job(16'hFFFF, 1'b0);
    send_job(16'h0001, 1'b0);
    send_job(16'h0000, 1'b1);
    steady = 1'b0;
  endtask

  // The receiver holds off while jobs keep coming, so the input must stall.
  task automatic check_output_backpressure();
    write_tills(4'd4);
    @(posedge clk);
    hold_off_left = PRESSURE_CYCLES;
    for (int k = 0; k < 12; k++) send_job(random_service_time(), k == 11);
  endtask

  // Batches of random length run across phases, so the count often changes mid-batch.
  task automatic check_random_mix();
    int                           batch_left;
    logic [llsd_pkg::TILLS_W-1:0] tills;
    batch_left = 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       tills = 4'd1;
        1:       tills = 4'd8;
        2:       tills = 4'd0;
        3:       tills = 4'd15;
        default: tills = 4'($urandom_range(0, 15));
      endcase
      write_tills(tills);
      @(posedge clk);
      steady = (phase == 5);
      for (int k = 0; k < JOBS_PER_PHASE; k++) begin
        if (batch_left == 0) begin
          batch_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 12);
        end
        send_job(random_service_time(), batch_left == 1);
        batch_left--;
      end
    end
    steady = 1'b0;
  endtask

  // Receiver: a long hold-off when asked, always ready in a steady run, otherwise a rotating stall pattern.
  always @(negedge clk) begin : ready_pattern_gen
    if (hold_off_left > 0) begin
      hold_off_left--;
      m_tready <= 1'b0;
    end else if (steady) begin
      m_tready <= 1'b1;
    end else begin
      if (pattern_age == 0) begin
        ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        pattern_age   = 48;
      end
      pattern_age--;
      m_tready     <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end
  end

  always @(posedge clk) begin : result_check
    dispatch_t got;
    dispatch_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.server_index = m_tdata[IDX_LSB +: 3];
      got.server_load  = m_tdata[LOAD_LSB +: 32];
      got.makespan     = m_tdata[SPAN_LSB +: 32];
      got.batch_done   = m_tlast;
      if (pending_dispatches.size() == 0) begin
        error_count++;
        $error("result beat with no job outstanding");
      end else begin
        want = pending_dispatches.pop_front();
        if (got.server_index !== want.server_index) begin
          error_count++;
          $error("server_index: expected %0d, got %0d", want.server_index, got.server_index);
        end
        if (got.server_load !== want.server_load) begin
          error_count++;
          $error("server_load: expected %0d, got %0d", want.server_load, got.server_load);
        end
        if (got.makespan !== want.makespan) begin
          error_count++;
          $error("makespan: expected %0d, got %0d", want.makespan, got.makespan);
        end
        if (got.batch_done !== want.batch_done) begin
          error_count++;
          $error("batch_done: expected %0d, got %0d", want.batch_done, got.batch_done);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (s_tvalid && !s_tready) input_stall_cycles++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : run
    for (int i = 0; i < llsd_pkg::SERVERS; i++) predicted_loads[i] = '0;
    predicted_makespan = '0;
    tills_setting      = 4'd1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    check_single_server_after_reset();
    check_tills_clamping_and_ties();
    check_steady_single_server();
    check_output_backpressure();
    check_random_mix();

    wait_idle();
    repeat (llsd_pkg::SERVERS + 4) @(posedge clk);
    $display("Covered %0d jobs in %0d closed batches over %0d server-count writes,",
             jobs_accepted, batches_closed, tills_writes);
    $display("with %0d saturating loads and %0d cycles of input stall.",
             saturated_jobs, input_stall_cycles);
    if (error_count == 0 && pending_dispatches.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/llsd_pkg.sv
design/llsd_cell.sv
design/least_loaded_server_dispatch.sv
verif/tb_least_loaded_server_dispatch.sv
